@@ rtl/stq_pkg.sv @@
// stq_pkg: beat types, status and function codes, and the wrap-aware time compare
// shared by the sorted timeout queue. No dependencies.
`default_nettype none

package stq_pkg;

	// function codes of a request beat
	localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
	localparam logic [1:0] FUNC_CYCLIC   = 2'd1;
	localparam logic [1:0] FUNC_CHECK    = 2'd2;
	localparam logic [1:0] FUNC_UNUSED   = 2'd3;

	// status codes of a response beat
	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_DROPPED  = 2'd1;
	localparam logic [1:0] STATUS_EXPIRED  = 2'd2;
	localparam logic [1:0] STATUS_NONE     = 2'd3;

	// most entries popped by one check
	localparam int MAX_RESULTS = 16;

	localparam logic [31:0] HALF_RANGE = 32'h7fff_ffff;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now;
		logic [30:0] delay;
		logic [7:0]  handler_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  expired_id;
		logic [31:0] due_time;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] due;
		logic [7:0]  handler;
	} entry_t;

	// a is before b when (a - b) mod 2^32 is at least half the range (2^31)
	function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return diff > HALF_RANGE;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sorted_timeout_queue_top.sv @@
// sorted_timeout_queue_top: timeout list kept in due-time order in a circular
// buffer memory. Depends on stq_pkg for beat types, codes and the time compare.
//
// Usage: a request beat (func, now, delay, handler_id) moves on req when
// req_valid is high and req_stall low; response beats leave on rsp the same way.
// Schedule and cyclic reschedule give one response beat (inserted or dropped).
// Check gives one beat per expired entry popped, at most MAX_RESULTS, or one
// "nothing expired" beat; last is set on the final beat of a request.
// An insert walks the list from the head, one entry a cycle, to find the place,
// writes the new entry there and moves the later entries up one slot; a
// schedule or cyclic reschedule on a full list is dropped without a walk. A
// check pops due entries one at a time, reading the head entry before each
// test, and stops at an entry not yet due, when the list runs empty, or when
// MAX_RESULTS is reached.
// One request is in work at a time: req_stall is high from acceptance until its
// last response beat is loaded into the output register.
// Reset empties the list (head, tail, count cleared) and clears last_due; the
// memory itself is not cleared. A stalled receiver holds the response register
// and the block waits with it; a request may be taken while the final response
// beat of the previous one is still waiting.
`default_nettype none

module sorted_timeout_queue_top #(
	parameter int DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire stq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output stq_pkg::rsp_t      rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int NW = $clog2(stq_pkg::MAX_RESULTS + 1);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_INS_START = 3'd1;
	localparam logic [2:0] ST_INS_CMP   = 3'd2;
	localparam logic [2:0] ST_INS_SHIFT = 3'd3;
	localparam logic [2:0] ST_CHK_RD    = 3'd4;
	localparam logic [2:0] ST_CHK_EV    = 3'd5;
	localparam logic [2:0] ST_EMIT      = 3'd6;

	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	// entry store, one write and one registered read a cycle
	stq_pkg::entry_t mem [DEPTH];
	stq_pkg::entry_t rd_q;

	logic [2:0]      state_q;
	logic [IW-1:0]   head_q;
	logic [IW-1:0]   tail_q;
	logic [CW-1:0]   cnt_q;
	logic [31:0]     last_due_q;
	stq_pkg::req_t   req_q;
	logic [31:0]     due_q;
	logic [IW-1:0]   pos_q;
	stq_pkg::entry_t carry_q;
	logic [NW-1:0]   n_q;
	logic            pend_v_q;
	stq_pkg::entry_t pend_q;
	stq_pkg::rsp_t   res_q;

	logic            out_free;
	logic            out_load;
	stq_pkg::rsp_t   out_data;
	logic            we;
	logic [IW-1:0]   waddr;
	stq_pkg::entry_t wdata;
	logic [IW-1:0]   raddr;
	logic            expired;
	logic            shift;
	logic            at_tail;
	logic            pop_go;
	stq_pkg::rsp_t   fin_res;
	logic [31:0]     new_due;
	logic [31:0]     cyc_due;

	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid || !rsp_stall;
	assign expired   = !stq_pkg::is_before(req_q.now, rd_q.due);
	assign shift     = stq_pkg::is_before(due_q, rd_q.due);
	assign at_tail   = (pos_q == tail_q);
	assign pop_go    = expired && (!pend_v_q || out_free);

	// due time of a new entry: now + delay, or for a cyclic reschedule last_due + delay unless that lies before now
	assign cyc_due = last_due_q + {1'b0, req.delay};
	assign new_due = (req.func == stq_pkg::FUNC_CYCLIC &&
	                  !stq_pkg::is_before(cyc_due, req.now)) ?
	                 cyc_due : req.now + {1'b0, req.delay};

	// closing beat of a check
	always_comb begin
		if (pend_v_q) begin
			fin_res = '{status: stq_pkg::STATUS_EXPIRED, expired_id: pend_q.handler,
			            due_time: pend_q.due, last: 1'b1};
		end else begin
			fin_res = '{status: stq_pkg::STATUS_NONE, expired_id: 8'd0,
			            due_time: 32'd0, last: 1'b1};
		end
	end

	// memory read address
	always_comb begin
		unique case (state_q)
			ST_INS_CMP:   raddr = idx_next(pos_q);
			ST_INS_SHIFT: raddr = idx_next(pos_q);
			default:      raddr = head_q;
		endcase
	end

	// memory write: drop the new entry in, or carry the displaced one up a slot
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = carry_q;
		if (state_q == ST_INS_CMP && (at_tail || shift)) begin
			we    = 1'b1;
			wdata = '{due: due_q, handler: req_q.handler_id};
		end else if (state_q == ST_INS_SHIFT) begin
			we = 1'b1;
		end
	end

	// output register load
	always_comb begin
		out_load = 1'b0;
		out_data = res_q;
		if (state_q == ST_EMIT) begin
			out_load = out_free;
		end else if (state_q == ST_CHK_EV && expired && pend_v_q && out_free) begin
			out_load = 1'b1;
			out_data = '{status: stq_pkg::STATUS_EXPIRED, expired_id: pend_q.handler,
			             due_time: pend_q.due, last: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp <= out_data;
		end
	end

	// sequencer and list pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			last_due_q <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						pend_v_q <= 1'b0;
						unique case (req.func)
							stq_pkg::FUNC_SCHEDULE, stq_pkg::FUNC_CYCLIC:
								state_q <= ST_INS_START;
							stq_pkg::FUNC_CHECK:
								state_q <= ST_CHK_RD;
							default:
								state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INS_START: begin
					if (cnt_q == CW'(DEPTH)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (at_tail) begin
						cnt_q   <= cnt_q + CW'(1);
						tail_q  <= idx_next(tail_q);
						state_q <= ST_EMIT;
					end else if (shift) begin
						state_q <= ST_INS_SHIFT;
					end
				end
				ST_INS_SHIFT: begin
					if (at_tail) begin
						cnt_q   <= cnt_q + CW'(1);
						tail_q  <= idx_next(tail_q);
						state_q <= ST_EMIT;
					end
				end
				ST_CHK_RD: begin
					if (cnt_q == '0 || n_q == NW'(stq_pkg::MAX_RESULTS)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CHK_EV;
					end
				end
				ST_CHK_EV: begin
					if (!expired) begin
						state_q <= ST_EMIT;
					end else if (pop_go) begin
						pend_v_q   <= 1'b1;
						last_due_q <= rd_q.due;
						head_q     <= idx_next(head_q);
						cnt_q      <= cnt_q - CW'(1);
						state_q    <= ST_CHK_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// work registers of the request in progress
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req;
				due_q <= new_due;
				n_q   <= '0;
			end
			ST_INS_START: begin
				pos_q <= head_q;
				if (cnt_q == CW'(DEPTH)) begin
					res_q <= '{status: stq_pkg::STATUS_DROPPED,
					           expired_id: req_q.handler_id, due_time: due_q, last: 1'b1};
				end else begin
					res_q <= '{status: stq_pkg::STATUS_INSERTED,
					           expired_id: req_q.handler_id, due_time: due_q, last: 1'b1};
				end
			end
			ST_INS_CMP: begin
				if (!at_tail) begin
					pos_q <= idx_next(pos_q);
					if (shift) begin
						carry_q <= rd_q;
					end
				end
			end
			ST_INS_SHIFT: begin
				pos_q   <= idx_next(pos_q);
				carry_q <= rd_q;
			end
			ST_CHK_RD: begin
				res_q <= fin_res;
			end
			ST_CHK_EV: begin
				if (!expired) begin
					res_q <= fin_res;
				end else if (pop_go) begin
					pend_q <= rd_q;
					n_q    <= n_q + NW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
